@@ design/smtl_pkg.sv @@
// Shared types and command codes for the two-list sort and merge block.
`default_nettype none

package smtl_pkg;

  localparam int WORD_W = 32;

  // Input command codes
  localparam logic [1:0] CMD_PUSH_FIRST  = 2'd0;
  localparam logic [1:0] CMD_PUSH_SECOND = 2'd1;
  localparam logic [1:0] CMD_RUN         = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic push_first;   // write value into first list
    logic push_second;  // write value into second list
    logic run_clear;    // run on two empty lists: clear drop flag only
    logic scan_init;    // start of a run: clear taken marks and emit counter
    logic scan_issue;   // read one entry at the scan pointer
    logic emit;         // load output register with the current minimum
  } smtl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic issue_last;   // scan pointer is on the last stored entry
    logic emit_last;    // next emitted item closes the run
    logic run_empty;    // both lists are empty
    logic slot_free;    // output register can take an item this cycle
  } smtl_status_t;

endpackage

`default_nettype wire

@@ design/smtl_dp.sv @@
// Datapath: list storage, minimum search over untaken entries, output register.
`default_nettype none

module smtl_dp
  import smtl_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire smtl_cmd_t                cmd,
  output smtl_status_t                  status,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic signed [WORD_W-1:0]      merged_value,
  output logic                          last_item,
  output logic                          any_dropped
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [WORD_W-1:0] mem_a [LIST_DEPTH];
  logic [WORD_W-1:0] mem_b [LIST_DEPTH];

  logic [CW-1:0]         count_a;
  logic [CW-1:0]         count_b;
  logic                  dropped;
  logic [LIST_DEPTH-1:0] taken_a;
  logic [LIST_DEPTH-1:0] taken_b;
  logic                  ptr_sel;
  logic [IW-1:0]         ptr_idx;
  logic                  rd_vld;
  logic                  rd_sel;
  logic [IW-1:0]         rd_idx;
  logic                  rd_taken;
  logic [WORD_W-1:0]     rd_a;
  logic [WORD_W-1:0]     rd_b;
  logic signed [WORD_W-1:0] best;
  logic                  best_found;
  logic                  best_sel;
  logic [IW-1:0]         best_idx;
  logic [CW:0]           emit_cnt;

  logic [CW:0]              total;
  logic [CW-1:0]            idx_inc;
  logic signed [WORD_W-1:0] rd_word;
  logic                     better;
  logic                     full_a;
  logic                     full_b;
  logic                     emit_last;

  assign total     = {1'b0, count_a} + {1'b0, count_b};
  assign idx_inc   = CW'(ptr_idx) + CW'(1);
  assign rd_word   = $signed(rd_sel ? rd_b : rd_a);
  assign better    = !rd_taken && (!best_found || (rd_word < best));
  assign full_a    = (count_a == CW'(LIST_DEPTH));
  assign full_b    = (count_b == CW'(LIST_DEPTH));
  assign emit_last = ((emit_cnt + (CW+1)'(1)) == total);

  assign status.issue_last = ptr_sel ? (idx_inc == count_b)
                                     : ((idx_inc == count_a) && (count_b == '0));
  assign status.emit_last  = emit_last;
  assign status.run_empty  = (total == '0);
  assign status.slot_free  = !out_valid || !out_stall;

  // List storage: one write port for pushes, one registered read at the pointer
  always_ff @(posedge clk) begin
    if (cmd.push_first && !full_a) begin
      mem_a[count_a[IW-1:0]] <= value;
    end
    if (cmd.push_second && !full_b) begin
      mem_b[count_b[IW-1:0]] <= value;
    end
    rd_a <= mem_a[ptr_idx];
    rd_b <= mem_b[ptr_idx];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      dropped    <= 1'b0;
      taken_a    <= '0;
      taken_b    <= '0;
      ptr_sel    <= 1'b0;
      ptr_idx    <= '0;
      rd_vld     <= 1'b0;
      best_found <= 1'b0;
      emit_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_issue;

      if (cmd.push_first) begin
        if (full_a) dropped <= 1'b1;
        else        count_a <= count_a + CW'(1);
      end
      if (cmd.push_second) begin
        if (full_b) dropped <= 1'b1;
        else        count_b <= count_b + CW'(1);
      end
      if (cmd.run_clear) begin
        dropped <= 1'b0;
      end

      if (cmd.scan_init) begin
        taken_a  <= '0;
        taken_b  <= '0;
        emit_cnt <= '0;
      end

      if (cmd.scan_init || cmd.emit) begin
        ptr_sel <= (count_a == '0);
        ptr_idx <= '0;
      end else if (cmd.scan_issue) begin
        if (!ptr_sel && (idx_inc == count_a)) begin
          ptr_sel <= 1'b1;
          ptr_idx <= '0;
        end else begin
          ptr_idx <= idx_inc[IW-1:0];
        end
      end

      if (cmd.scan_init || cmd.emit) begin
        best_found <= 1'b0;
      end else if (rd_vld && better) begin
        best_found <= 1'b1;
      end

      if (cmd.emit) begin
        if (best_sel) taken_b[best_idx] <= 1'b1;
        else          taken_a[best_idx] <= 1'b1;
        emit_cnt <= emit_cnt + (CW+1)'(1);
        if (emit_last) begin
          count_a <= '0;
          count_b <= '0;
          dropped <= 1'b0;
        end
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_sel   <= ptr_sel;
      rd_idx   <= ptr_idx;
      rd_taken <= ptr_sel ? taken_b[ptr_idx] : taken_a[ptr_idx];
    end
    if (rd_vld && better) begin
      best     <= rd_word;
      best_sel <= rd_sel;
      best_idx <= rd_idx;
    end
    if (cmd.emit) begin
      merged_value <= best;
      last_item    <= emit_last;
      any_dropped  <= dropped;
    end
  end

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("item loaded while output register holds a stalled item");

  a_emit_has_minimum: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> best_found)
    else $error("emit without any untaken entry found by the scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CW'(LIST_DEPTH)) && (count_b <= CW'(LIST_DEPTH)))
    else $error("list count beyond depth");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && emit_last) |=> ((count_a == '0) && (count_b == '0) && !dropped))
    else $error("lists not emptied after the last item of a run");

endmodule

`default_nettype wire

@@ design/smtl_ctrl.sv @@
// Controller: input handshake, run sequencing of scan, drain and emit steps.
`default_nettype none

module smtl_ctrl
  import smtl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   command,
  input  wire smtl_status_t status,
  output smtl_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_PUSH_FIRST:  cmd.push_first  = 1'b1;
            CMD_PUSH_SECOND: cmd.push_second = 1'b1;
            CMD_RUN: begin
              if (status.run_empty) begin
                cmd.run_clear = 1'b1;
              end else begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.issue_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = status.emit_last ? S_IDLE : S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && status.issue_last) |=> (state == S_DRAIN))
    else $error("scan did not stop on the last entry");

  a_drain_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_EMIT))
    else $error("drain not followed by emit");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_init |=> (state == S_SCAN))
    else $error("run started without entering scan");

endmodule

`default_nettype wire

@@ design/sort_and_merge_two_lists_core.sv @@
// Top level of the two-list sort and merge block: controller plus datapath.
// Push items are taken one per cycle outside a run; each push finishes in that cycle, no result.
// A run over n = n1 + n2 stored values emits n items; for each item the controller
// reads every stored entry from the single-read list memories, drains the compare
// and loads the output register, so input is stalled for the whole run plus output stall.
// Sync reset clears counts, drop flag, controller and output valid; lists are not cleared.
`default_nettype none

module sort_and_merge_two_lists_core
  import smtl_pkg::*;
#(
  parameter int LIST_DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // input item channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               command,
  input  wire logic signed [WORD_W-1:0] value,
  // result item channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [WORD_W-1:0]      merged_value,
  output logic                          last_item,
  output logic                          any_dropped
);

  // The run works as a repeated minimum search: each pass reads every stored
  // entry of both lists in turn, skips entries already emitted in this run,
  // and keeps the smallest signed value. Equal values are interchangeable,
  // so the output order matches a sort of each list followed by a merge.
  smtl_cmd_t    cmd;
  smtl_status_t status;

  smtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  // Output register in the datapath parts the result side from the search,
  // so the last item of a run can wait while new pushes are taken.
  smtl_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .merged_value (merged_value),
    .last_item    (last_item),
    .any_dropped  (any_dropped)
  );

endmodule

`default_nettype wire
